### sv/bis_pkg.sv
// Shared types and constants for the bounded integer set table.
// No dependencies; imported by bis_core and bounded_integer_set_table.
package bis_pkg;

  localparam int MODE_W       = 2;
  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 5;
  localparam int IN_DATA_W    = 32;
  localparam int OUT_DATA_W   = 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - 2 - COUNT_W;
  localparam int CAPACITY_DEF = 16;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd3;

  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic               found;
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } res_t;

endpackage

### sv/bis_core.sv
// Set storage: entry registers, fill count, parallel compare and compaction.
// Depends on bis_pkg; instantiated by bounded_integer_set_table.
module bis_core #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_en,
  input  bis_pkg::mode_t  req_mode,
  input  bis_pkg::value_t req_value,
  output bis_pkg::res_t   res
);
  import bis_pkg::*;

  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  value_t            ent_r [CAPACITY];
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] sh_en;
  logic [IDX_W-1:0]    slot;
  logic                found;
  logic                full;
  logic                add_do;
  logic                rem_do;
  logic                ovf;

  always_comb begin
    slot = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (FILL_W'(i) < fill_r) && (ent_r[i] == req_value);
      if (match[i]) begin
        slot = slot | IDX_W'(i);
      end
    end
    found = |match;
    for (int i = 0; i < CAPACITY; i++) begin
      sh_en[i] = found && (IDX_W'(i) >= slot);
    end
  end

  assign full   = (fill_r == FILL_W'(CAPACITY));
  assign add_do = (req_mode == MODE_ADD) && !found && !full;
  assign rem_do = (req_mode == MODE_REMOVE) && found;
  assign ovf    = (req_mode == MODE_ADD) && !found && full;

  always_comb begin
    fill_nxt = fill_r;
    unique case (req_mode)
      MODE_CLEAR:  fill_nxt = '0;
      MODE_ADD:    if (add_do) fill_nxt = fill_r + FILL_W'(1);
      MODE_REMOVE: if (rem_do) fill_nxt = fill_r - FILL_W'(1);
      MODE_MEMBER: fill_nxt = fill_r;
      default:     fill_nxt = fill_r;
    endcase
  end

  assign res.found    = (req_mode != MODE_CLEAR) && found;
  assign res.overflow = ovf;
  assign res.count    = COUNT_W'(fill_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (req_en) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req_en) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (add_do && (fill_r == FILL_W'(i))) begin
          ent_r[i] <= req_value;
        end else if (rem_do && sh_en[i] && (i + 1 < CAPACITY)) begin
          ent_r[i] <= ent_r[(i + 1 < CAPACITY) ? i + 1 : i];
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  a_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("duplicate value held in set");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    req_en && ovf |-> full && !found)
    else $error("overflow without full set");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    req_en && (req_mode == MODE_CLEAR) |=> fill_r == '0)
    else $error("clear did not empty set");

  a_add_grow: assert property (@(posedge clk) disable iff (!rst_n)
    req_en && add_do |=> fill_r == $past(fill_r) + FILL_W'(1))
    else $error("add did not grow set");
`endif

endmodule

### sv/bounded_integer_set_table.sv
// Bounded integer set table: one set request per transaction, one result per request.
// Accepts one transaction per cycle while in_tready is high; the result passes through the input
// register, then the result register, before it is valid on out_tdata. With
// out_tready low the block holds two transactions, then stalls in_tready. The
// compare/compaction over all entries is combinational.
// Depends on bis_pkg and bis_core.
module bounded_integer_set_table #(
  parameter int CAPACITY = bis_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [bis_pkg::IN_DATA_W-1:0]  in_tdata,   // value[31:0]
  input  logic [bis_pkg::MODE_W-1:0]     in_tuser,   // mode[1:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bis_pkg::OUT_DATA_W-1:0] out_tdata   // pad, count[4:0], overflow, found (MSB to LSB)
);
  import bis_pkg::*;

  logic   s1_vld_r,   s1_vld_nxt;
  mode_t  s1_mode_r;
  value_t s1_value_r;
  logic   out_vld_r,  out_vld_nxt;
  res_t   out_res_r;
  res_t   res;
  logic   out_adv;
  logic   req_en;

  assign out_adv   = !out_vld_r || out_tready;
  assign in_tready = !s1_vld_r || out_adv;
  assign req_en    = s1_vld_r && out_adv;

  assign s1_vld_nxt  = in_tready ? in_tvalid : s1_vld_r;
  assign out_vld_nxt = out_adv ? s1_vld_r : out_vld_r;

  bis_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_en    (req_en),
    .req_mode  (s1_mode_r),
    .req_value (s1_value_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r  <= in_tuser;
      s1_value_r <= in_tdata[VALUE_W-1:0];
    end
    if (req_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res_r.count, out_res_r.overflow,
                       out_res_r.found};

endmodule
